@@ rtl/core/ses_pkg.sv @@
// ----------------------------------------------------------------------------
// ses_pkg
// Shared types, codes and constants of the stroke emboss shader.
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

   localparam int MAP_WIDTH  = 128;
   localparam int MAP_HEIGHT = 128;
   localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W     = $clog2(MAP_DEPTH);
   localparam int COORD_W    = $clog2(MAP_WIDTH);

   localparam int DIV_NUM_W  = 26;
   localparam int DIV_DEN_W  = 13;
   localparam int SQ_IN_W    = 44;
   localparam int SQ_OUT_W   = SQ_IN_W / 2;
   localparam int SQ_REM_W   = SQ_OUT_W + 2;

   typedef enum logic [1:0] {
      CMD_STAMP = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } ses_cmd_type;

   typedef enum logic [1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_NONE   = 2'd3
   } ses_csr_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] pos_x;
      logic [6:0] pos_y;
      logic       ink;
   } ses_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } ses_rsp_type;

   typedef struct packed {
      logic [7:0] dval;
      logic [7:0] ox;
      logic [7:0] oy;
   } ses_entry_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } ses_div_req_type;

   typedef struct packed {
      logic               start;
      logic [SQ_IN_W-1:0] opnd;
   } ses_sq_req_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ST_CHECK,
      S_ST_SQRT,
      S_ST_DIVN,
      S_ST_DIVX,
      S_ST_DIVY,
      S_RD_WAIT,
      S_RD_EVAL,
      S_SH_SQRT,
      S_SH_MAC,
      S_SH_GLOSS,
      S_SH_SUM,
      S_SH_FIN,
      S_OUT
   } ses_state_type;

   localparam ses_entry_type MAP_RESET = '{dval: 8'd255, ox: 8'd0, oy: 8'd0};

   localparam logic [4:0] RADIUS_RESET = 5'd21;
   localparam logic [7:0] WIDTH_RESET  = 8'd128;
   localparam logic [7:0] HEIGHT_RESET = 8'd128;

   localparam logic signed [15:0] L_X = -16'sd6785;
   localparam logic signed [15:0] L_Y = -16'sd14701;
   localparam logic signed [15:0] L_Z = 16'sd7916;
   localparam logic signed [15:0] G_X = -16'sd3636;
   localparam logic signed [15:0] G_Y = -16'sd7877;
   localparam logic signed [15:0] G_Z = 16'sd13898;

   localparam logic signed [35:0] GLOSS_LO_Q = 36'sd217169920;
   localparam logic signed [35:0] GLOSS_HI_Q = 36'sd255295488;
   localparam logic [12:0] GLOSS_DEN = 13'd4654;
   localparam logic [13:0] AMBIENT   = 14'd8192;
   localparam logic [13:0] GLOSS_MAX = 14'd8192;
   localparam logic [7:0]  DIST_LIMIT = 8'd200;

   // ceil(2^28/25) and ceil(2^37/2327)
   localparam logic [23:0] RECIP_25   = 24'd10737419;
   localparam logic [25:0] RECIP_2327 = 26'd59062722;

endpackage

`default_nettype wire

@@ rtl/core/stroke_emboss_shader.sv @@
// ----------------------------------------------------------------------------
// stroke_emboss_shader
// Distance-stamp map in one synchronous RAM with embossed RGBA shading.
//
// Request words (req_*) carry a command: stamp a disk around (pos_x,pos_y)
// when ink is set, read the shaded pixel at (pos_x,pos_y), or clear the map.
// Only a read returns a word on the rsp_* channel. One word is worked on at
// a time; req_stall is high while it is in progress.
// After reset, and for every clear word, the block sweeps the 16384-entry
// map one entry per cycle with req_stall high.
// A stamp visits (2R+1)^2 window positions; one inside the disk and frame
// runs the bit-serial square root, then three divides on the divider.
// A read of a pixel in the frame with a distance under 200 runs a square
// root, six MAC steps and reciprocal multiplies for the constant divides.
// A finished result sits in an output register while the next word is
// accepted; if rsp_stall holds it, a following read waits at its last step.
// Configuration writes (csr_*) take effect at once; the user must see that
// they are made while idle, for the block has no check of its own for it.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_emboss_shader (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ses_pkg::ses_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ses_pkg::ses_rsp_type       rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data
);

   ses_pkg::ses_state_type state_ff, state_in;

   ses_pkg::ses_entry_type map_mem [ses_pkg::MAP_DEPTH];
   ses_pkg::ses_entry_type rd_ff;
   logic                               mem_re, mem_we;
   logic [ses_pkg::ADDR_W-1:0]         mem_raddr, mem_waddr, clr_ff;
   ses_pkg::ses_entry_type             mem_wdata;

   logic [4:0] rad_ff;
   logic [7:0] fw_ff, fh_ff;

   logic [6:0]        cx_ff, cy_ff;
   logic signed [6:0] dx_ff, dy_ff;
   logic [7:0]        n_ff, ox_ff;
   logic signed [15:0] xq_ff, yq_ff;
   logic [14:0]       zq_ff;
   logic signed [35:0] acc_ff, dot_ff, gl_ff;
   logic [2:0]        step_ff;
   logic [13:0]       gloss_ff;
   logic [20:0]       lq_ff;
   ses_pkg::ses_rsp_type res_ff;
   logic              rsp_valid_ff;
   ses_pkg::ses_rsp_type rsp_data_ff;

   ses_pkg::ses_div_req_type           dv_req;
   logic                               dv_done;
   logic [ses_pkg::DIV_NUM_W-1:0]      dv_quot;
   ses_pkg::ses_sq_req_type            sq_req;
   logic                               sq_done;
   logic [ses_pkg::SQ_OUT_W-1:0]       sq_root;

   logic              accept, out_free;
   logic [6:0]        neg_rad;
   logic signed [8:0] px_s, py_s;
   logic [4:0]        adx, ady;
   logic [10:0]       d2;
   logic [9:0]        r2;
   logic              pix_in, last_x, last_y;
   logic [7:0]        dxr, dyr;
   logic [ses_pkg::ADDR_W-1:0] stamp_addr;
   logic              rd_out;
   logic [15:0]       zrem;
   logic              xneg, yneg;
   logic [7:0]        xmag, ymag;
   logic [21:0]       zsum, xnum, ynum;
   logic [42:0]       zprod;
   logic [43:0]       xprod, yprod;
   logic [25:0]       gdiff;
   logic [50:0]       gprod;
   logic signed [15:0] mac_a, mac_c;
   logic signed [31:0] prod;
   logic signed [35:0] acc_sum;
   logic [19:0]       dot_q;
   logic              gl_low, gl_high;
   logic [28:0]       lint_full;
   logic [14:0]       lint;
   logic [7:0]        lint_red, lint_grn;

   ses_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (dv_req),
      .div_done (dv_done),
      .div_quot (dv_quot)
   );

   ses_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .sq_req  (sq_req),
      .sq_done (sq_done),
      .sq_root (sq_root)
   );

   assign req_stall = state_ff != ses_pkg::S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stamp window geometry and read frame check
   always_comb begin
      neg_rad    = 7'd0 - {2'b00, rad_ff};
      px_s       = $signed({2'b00, cx_ff}) + $signed({{2{dx_ff[6]}}, dx_ff});
      py_s       = $signed({2'b00, cy_ff}) + $signed({{2{dy_ff[6]}}, dy_ff});
      adx        = dx_ff[6] ? 5'(-dx_ff) : dx_ff[4:0];
      ady        = dy_ff[6] ? 5'(-dy_ff) : dy_ff[4:0];
      d2         = 11'(adx * adx) + 11'(ady * ady);
      r2         = 10'(rad_ff * rad_ff);
      pix_in     = !px_s[8] && !px_s[7] && (px_s[7:0] < fw_ff)
                   && !py_s[8] && !py_s[7] && (py_s[7:0] < fh_ff)
                   && (d2 < {1'b0, r2});
      last_x     = dx_ff == $signed({2'b00, rad_ff});
      last_y     = dy_ff == $signed({2'b00, rad_ff});
      dxr        = {dx_ff[6], dx_ff} + {3'b000, rad_ff};
      dyr        = {dy_ff[6], dy_ff} + {3'b000, rad_ff};
      stamp_addr = {py_s[6:0], px_s[6:0]};
      rd_out     = ({1'b0, req_data.pos_x} >= fw_ff) || ({1'b0, req_data.pos_y} >= fh_ff);
   end

   // shading arithmetic
   always_comb begin
      zrem    = 16'(16'd40000 - 16'(rd_ff.dval * rd_ff.dval));
      xneg    = rd_ff.ox < 8'd100;
      yneg    = rd_ff.oy < 8'd100;
      xmag    = xneg ? 8'd100 - rd_ff.ox : rd_ff.ox - 8'd100;
      ymag    = yneg ? 8'd100 - rd_ff.oy : rd_ff.oy - 8'd100;
      zsum    = sq_root + 22'd100;
      zprod   = zsum[21:3] * ses_pkg::RECIP_25;
      xnum    = {xmag, 14'd0} + 22'd50;
      ynum    = {ymag, 14'd0} + 22'd50;
      xprod   = xnum[21:2] * ses_pkg::RECIP_25;
      yprod   = ynum[21:2] * ses_pkg::RECIP_25;
      case (step_ff)
         3'd0: begin mac_a = xq_ff; mac_c = ses_pkg::L_X; end
         3'd1: begin mac_a = yq_ff; mac_c = ses_pkg::L_Y; end
         3'd2: begin mac_a = $signed({1'b0, zq_ff}); mac_c = ses_pkg::L_Z; end
         3'd3: begin mac_a = xq_ff; mac_c = ses_pkg::G_X; end
         3'd4: begin mac_a = yq_ff; mac_c = ses_pkg::G_Y; end
         default: begin mac_a = $signed({1'b0, zq_ff}); mac_c = ses_pkg::G_Z; end
      endcase
      prod    = mac_a * mac_c;
      acc_sum = ((step_ff == 3'd0 || step_ff == 3'd3) ? 36'sd0 : acc_ff) + 36'(prod);
      dot_q   = dot_ff[35] ? 20'd0 : 20'((dot_ff + 36'sd8192) >>> 14);
      gl_low  = gl_ff < ses_pkg::GLOSS_LO_Q;
      gl_high = gl_ff > ses_pkg::GLOSS_HI_Q;
      gdiff   = 26'(gl_ff - ses_pkg::GLOSS_LO_Q);
      gprod   = gdiff[25:1] * ses_pkg::RECIP_2327;
      lint_full = 29'(lq_ff) * 29'd255;
      lint      = 15'(lint_full >> 14);
      if (lint > 15'd510) lint = 15'd510;
      lint_red  = (lint > 15'd255) ? 8'd255 : lint[7:0];
      lint_grn  = (lint > 15'd255) ? 8'(lint - 15'd255) : 8'd0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ses_pkg::S_CLEAR:
            if (&clr_ff) state_in = ses_pkg::S_IDLE;
         ses_pkg::S_IDLE:
            if (accept) begin
               case (req_data.cmd)
                  ses_pkg::CMD_STAMP:
                     if (req_data.ink && rad_ff != 5'd0) state_in = ses_pkg::S_ST_CHECK;
                  ses_pkg::CMD_READ:
                     state_in = rd_out ? ses_pkg::S_OUT : ses_pkg::S_RD_WAIT;
                  ses_pkg::CMD_CLEAR:
                     state_in = ses_pkg::S_CLEAR;
                  default: state_in = ses_pkg::S_IDLE;
               endcase
            end
         ses_pkg::S_ST_CHECK:
            if (pix_in) state_in = ses_pkg::S_ST_SQRT;
            else if (last_x && last_y) state_in = ses_pkg::S_IDLE;
         ses_pkg::S_ST_SQRT: if (sq_done) state_in = ses_pkg::S_ST_DIVN;
         ses_pkg::S_ST_DIVN: if (dv_done) state_in = ses_pkg::S_ST_DIVX;
         ses_pkg::S_ST_DIVX: if (dv_done) state_in = ses_pkg::S_ST_DIVY;
         ses_pkg::S_ST_DIVY:
            if (dv_done) state_in = (last_x && last_y) ? ses_pkg::S_IDLE : ses_pkg::S_ST_CHECK;
         ses_pkg::S_RD_WAIT: state_in = ses_pkg::S_RD_EVAL;
         ses_pkg::S_RD_EVAL:
            state_in = (rd_ff.dval < ses_pkg::DIST_LIMIT) ? ses_pkg::S_SH_SQRT : ses_pkg::S_OUT;
         ses_pkg::S_SH_SQRT: if (sq_done) state_in = ses_pkg::S_SH_MAC;
         ses_pkg::S_SH_MAC:  if (step_ff == 3'd5) state_in = ses_pkg::S_SH_GLOSS;
         ses_pkg::S_SH_GLOSS: state_in = ses_pkg::S_SH_SUM;
         ses_pkg::S_SH_SUM:  state_in = ses_pkg::S_SH_FIN;
         ses_pkg::S_SH_FIN:  state_in = ses_pkg::S_OUT;
         ses_pkg::S_OUT:     if (out_free) state_in = ses_pkg::S_IDLE;
         default: state_in = ses_pkg::S_IDLE;
      endcase
   end

   // unit and memory controls
   always_comb begin
      sq_req    = '0;
      dv_req    = '0;
      mem_re    = 1'b0;
      mem_raddr = stamp_addr;
      mem_we    = 1'b0;
      mem_waddr = stamp_addr;
      mem_wdata = ses_pkg::MAP_RESET;
      case (state_ff)
         ses_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ses_pkg::S_ST_CHECK: begin
            sq_req.start = pix_in;
            sq_req.opnd  = ses_pkg::SQ_IN_W'(26'(d2) * 26'd40000);
         end
         ses_pkg::S_ST_SQRT: begin
            dv_req.start = sq_done;
            dv_req.num   = ses_pkg::DIV_NUM_W'(sq_root);
            dv_req.den   = ses_pkg::DIV_DEN_W'(rad_ff);
         end
         ses_pkg::S_ST_DIVN: begin
            dv_req.start = dv_done;
            dv_req.num   = ses_pkg::DIV_NUM_W'(dxr[6:0] * 14'd100);
            dv_req.den   = ses_pkg::DIV_DEN_W'(rad_ff);
         end
         ses_pkg::S_ST_DIVX: begin
            dv_req.start = dv_done;
            dv_req.num   = ses_pkg::DIV_NUM_W'(dyr[6:0] * 14'd100);
            dv_req.den   = ses_pkg::DIV_DEN_W'(rad_ff);
            mem_re       = 1'b1;
         end
         ses_pkg::S_ST_DIVY: begin
            mem_we    = dv_done && (n_ff < rd_ff.dval);
            mem_wdata = '{dval: n_ff, ox: ox_ff, oy: dv_quot[7:0]};
         end
         ses_pkg::S_RD_WAIT: begin
            mem_re    = 1'b1;
            mem_raddr = {cy_ff, cx_ff};
         end
         ses_pkg::S_RD_EVAL: begin
            sq_req.start = rd_ff.dval < ses_pkg::DIST_LIMIT;
            sq_req.opnd  = {zrem, 28'd0};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ses_pkg::S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ses_pkg::S_CLEAR) clr_ff <= clr_ff + 1'b1;
         else clr_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff <= ses_pkg::RADIUS_RESET;
         fw_ff  <= ses_pkg::WIDTH_RESET;
         fh_ff  <= ses_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ses_pkg::CSR_RADIUS: rad_ff <= csr_data[4:0];
            ses_pkg::CSR_WIDTH:  fw_ff  <= csr_data;
            ses_pkg::CSR_HEIGHT: fh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ses_pkg::S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ses_pkg::S_OUT && out_free) rsp_data_ff <= res_ff;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ses_pkg::S_IDLE: begin
            cx_ff  <= req_data.pos_x;
            cy_ff  <= req_data.pos_y;
            dx_ff  <= $signed(neg_rad);
            dy_ff  <= $signed(neg_rad);
            res_ff <= '0;
         end
         ses_pkg::S_ST_CHECK:
            if (!pix_in) begin
               if (last_x) begin
                  dx_ff <= $signed(neg_rad);
                  dy_ff <= dy_ff + 7'sd1;
               end else begin
                  dx_ff <= dx_ff + 7'sd1;
               end
            end
         ses_pkg::S_ST_DIVN: if (dv_done) n_ff  <= dv_quot[7:0];
         ses_pkg::S_ST_DIVX: if (dv_done) ox_ff <= dv_quot[7:0];
         ses_pkg::S_ST_DIVY:
            if (dv_done) begin
               if (last_x) begin
                  dx_ff <= $signed(neg_rad);
                  dy_ff <= dy_ff + 7'sd1;
               end else begin
                  dx_ff <= dx_ff + 7'sd1;
               end
            end
         ses_pkg::S_RD_EVAL:
            res_ff <= '{red: 8'd0, green: 8'd0, blue: 8'd0,
                        alpha: (rd_ff.dval != 8'd255) ? 8'd255 : 8'd0};
         ses_pkg::S_SH_SQRT: begin
            step_ff <= 3'd0;
            if (sq_done) begin
               zq_ff <= zprod[42:28];
               xq_ff <= xneg ? -$signed(xprod[43:28]) : $signed(xprod[43:28]);
               yq_ff <= yneg ? -$signed(yprod[43:28]) : $signed(yprod[43:28]);
            end
         end
         ses_pkg::S_SH_MAC: begin
            acc_ff  <= acc_sum;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd2) dot_ff <= acc_sum;
            if (step_ff == 3'd5) gl_ff  <= acc_sum;
         end
         ses_pkg::S_SH_GLOSS:
            gloss_ff <= gl_high ? ses_pkg::GLOSS_MAX : (gl_low ? 14'd0 : gprod[50:37]);
         ses_pkg::S_SH_SUM:
            lq_ff <= 21'(dot_q) + 21'(ses_pkg::AMBIENT) + 21'(gloss_ff);
         ses_pkg::S_SH_FIN: begin
            res_ff.red   <= lint_red;
            res_ff.green <= lint_grn;
            res_ff.blue  <= lint_grn;
            res_ff.alpha <= 8'd255;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/ses_div.sv @@
// ----------------------------------------------------------------------------
// ses_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module ses_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ses_pkg::ses_div_req_type           div_req,
   output logic                                    div_done,
   output logic [ses_pkg::DIV_NUM_W-1:0]           div_quot
);

   localparam int CNT_W = $clog2(ses_pkg::DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ses_pkg::DIV_NUM_W - 1);

   logic [ses_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [ses_pkg::DIV_DEN_W:0]   rem_ff, rem_in, rem_t;
   logic [ses_pkg::DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          busy_ff, done_ff;
   logic                          ge;

   always_comb begin
      rem_t  = {rem_ff[ses_pkg::DIV_DEN_W-1:0], num_ff[ses_pkg::DIV_NUM_W-1]};
      ge     = rem_t >= {1'b0, den_ff};
      rem_in = ge ? rem_t - {1'b0, den_ff} : rem_t;
      num_in = {num_ff[ses_pkg::DIV_NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= div_req.num;
         den_ff <= div_req.den;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign div_done = done_ff;
   assign div_quot = num_ff;

endmodule

`default_nettype wire

@@ rtl/core/ses_sqrt.sv @@
// ----------------------------------------------------------------------------
// ses_sqrt
// Integer square root, floor, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ses_sqrt (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ses_pkg::ses_sq_req_type            sq_req,
   output logic                                    sq_done,
   output logic [ses_pkg::SQ_OUT_W-1:0]            sq_root
);

   localparam int CNT_W = $clog2(ses_pkg::SQ_OUT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ses_pkg::SQ_OUT_W - 1);

   logic [ses_pkg::SQ_IN_W-1:0]  opnd_ff;
   logic [ses_pkg::SQ_OUT_W-1:0] root_ff, root_in;
   logic [ses_pkg::SQ_REM_W-1:0] rem_ff, rem_in, rem_t, trial;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff, done_ff;

   always_comb begin
      rem_t   = {rem_ff[ses_pkg::SQ_REM_W-3:0],
                 opnd_ff[ses_pkg::SQ_IN_W-1:ses_pkg::SQ_IN_W-2]};
      trial   = {root_ff, 2'b01};
      if (rem_t >= trial) begin
         rem_in  = rem_t - trial;
         root_in = {root_ff[ses_pkg::SQ_OUT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_t;
         root_in = {root_ff[ses_pkg::SQ_OUT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (sq_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_req.start) begin
         opnd_ff <= sq_req.opnd;
         root_ff <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         opnd_ff <= {opnd_ff[ses_pkg::SQ_IN_W-3:0], 2'b00};
         root_ff <= root_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign sq_done = done_ff;
   assign sq_root = root_ff;

endmodule

`default_nettype wire

@@ tb/sv/stroke_emboss_shader_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stroke_emboss_shader_checker
// Watches the request, result and register ports of the shader, keeps its
// own distance map and register copies, works out the shaded pixel of every
// read word and compares each result word field by field, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_emboss_shader_checker
   import ses_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire ses_req_type  req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire ses_rsp_type  rsp_data,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_data,
   output int                fail_count,
   output int                pending,
   output int                words_out
);

   logic [7:0]  dist_map [MAP_DEPTH];
   logic [7:0]  ox_map   [MAP_DEPTH];
   logic [7:0]  oy_map   [MAP_DEPTH];
   logic [4:0]  radius;
   logic [7:0]  width;
   logic [7:0]  height;
   ses_rsp_type shaded_q [$];

   initial begin
      fail_count = 0;
      words_out  = 0;
   end

   assign pending = shaded_q.size();

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned one;
      root = 0;
      one  = 64'd1 << 62;
      while (one > v) one >>= 2;
      while (one != 0) begin
         if (v >= root + one) begin
            v    = v - (root + one);
            root = (root >> 1) + one;
         end else begin
            root >>= 1;
         end
         one >>= 2;
      end
      return root;
   endfunction

   function automatic longint round_div(longint n, longint d);
      return (n >= 0) ? (n + d / 2) / d : -((-n + d / 2) / d);
   endfunction

   function automatic int frame_cols();
      return (width > MAP_WIDTH) ? MAP_WIDTH : int'(width);
   endfunction

   function automatic int frame_rows();
      return (height > MAP_HEIGHT) ? MAP_HEIGHT : int'(height);
   endfunction

   function automatic void wipe_map();
      foreach (dist_map[i]) begin
         dist_map[i] = 8'd255;
         ox_map[i]   = 8'd0;
         oy_map[i]   = 8'd0;
      end
   endfunction

   function automatic void stamp_disk(int cx, int cy);
      int r;
      int px;
      int py;
      int d2;
      int n;
      int idx;
      r = int'(radius);
      if (r == 0) return;
      for (int dy = -r; dy <= r; dy++) begin
         py = cy + dy;
         if (py < 0 || py >= frame_rows()) continue;
         for (int dx = -r; dx <= r; dx++) begin
            px = cx + dx;
            if (px < 0 || px >= frame_cols()) continue;
            d2 = dx * dx + dy * dy;
            if (d2 >= r * r) continue;
            n   = int'(int_sqrt(longint'(40000) * d2)) / r;
            idx = py * MAP_WIDTH + px;
            if (n < int'(dist_map[idx])) begin
               dist_map[idx] = n[7:0];
               ox_map[idx]   = 8'((100 * (dx + r)) / r);
               oy_map[idx]   = 8'((100 * (dy + r)) / r);
            end
         end
      end
   endfunction

   function automatic ses_rsp_type shade_pixel(int px, int py);
      ses_rsp_type px_out;
      int     idx;
      int     d;
      longint xq;
      longint yq;
      longint zq;
      longint diff;
      longint gl;
      longint lint;
      px_out = '0;
      if (px >= frame_cols() || py >= frame_rows()) return px_out;
      idx = py * MAP_WIDTH + px;
      d   = int'(dist_map[idx]);
      if (d == 255) return px_out;
      px_out.alpha = 8'd255;
      if (d >= 200) return px_out;
      xq = round_div((longint'(ox_map[idx]) - 100) * 16384, 100);
      yq = round_div((longint'(oy_map[idx]) - 100) * 16384, 100);
      zq = longint'((int_sqrt(longint'(40000 - d * d) << 28) + 100) / 200);
      diff = xq * longint'(L_X) + yq * longint'(L_Y) + zq * longint'(L_Z);
      diff = (diff < 0) ? 0 : (diff + 8192) >>> 14;
      gl = xq * longint'(G_X) + yq * longint'(G_Y) + zq * longint'(G_Z);
      if (gl < longint'(GLOSS_LO_Q)) gl = 0;
      else if (gl > longint'(GLOSS_HI_Q)) gl = longint'(GLOSS_MAX);
      else gl = (gl - longint'(GLOSS_LO_Q)) / longint'(GLOSS_DEN);
      lint = ((diff + longint'(AMBIENT) + gl) * 255) >>> 14;
      if (lint > 510) lint = 510;
      px_out.red   = (lint > 255) ? 8'd255 : 8'(lint);
      px_out.green = (lint > 255) ? 8'(lint - 255) : 8'd0;
      px_out.blue  = px_out.green;
      return px_out;
   endfunction

   always @(posedge clock) begin
      ses_rsp_type want;
      if (reset) begin
         wipe_map();
         radius = RADIUS_RESET;
         width  = WIDTH_RESET;
         height = HEIGHT_RESET;
         shaded_q.delete();
      end else begin
         if (csr_write) begin
            case (ses_csr_type'(csr_index))
               CSR_RADIUS: radius = csr_data[4:0];
               CSR_WIDTH:  width  = csr_data;
               CSR_HEIGHT: height = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (ses_cmd_type'(req_data.cmd))
               CMD_STAMP: if (req_data.ink) stamp_disk(req_data.pos_x, req_data.pos_y);
               CMD_CLEAR: wipe_map();
               CMD_READ:  shaded_q.push_back(shade_pixel(req_data.pos_x, req_data.pos_y));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            words_out++;
            if (shaded_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word %h", rsp_data);
            end else begin
               want = shaded_q.pop_front();
               if (want.red != rsp_data.red || want.green != rsp_data.green ||
                   want.blue != rsp_data.blue || want.alpha != rsp_data.alpha) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                              want.red, want.green, want.blue, want.alpha, rsp_data.red,
                              rsp_data.green, rsp_data.blue, rsp_data.alpha);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/stroke_emboss_shader_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stroke_emboss_shader_test
// Drives stamp, read, clear and no-op words into the shader under several radius
// and frame settings with random idling and one long result hold-off; the
// checker beside the block predicts and compares every shaded pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_emboss_shader_test;
   import ses_pkg::*;

   localparam int WATCHDOG = 200000;
   localparam int PHASES   = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ses_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ses_rsp_type rsp_data;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;
   int          fail_count;
   int          pending;
   int          words_out;
   bit          calm;
   bit          held;
   int          quiet;
   int          cx;
   int          cy;

   int ph_radius [PHASES] = '{1, 4, 2, 6, 31, 0, 2, 5, 7, 21};
   int ph_cols   [PHASES] = '{128, 128, 128, 70, 8, 128, 1, 255, 200, 16};
   int ph_rows   [PHASES] = '{128, 128, 128, 90, 8, 128, 1, 0, 128, 16};
   int ph_words  [PHASES] = '{40, 60, 60, 30, 20, 15, 15, 15, 25, 15};

   stroke_emboss_shader u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_write, .csr_index, .csr_data
   );

   stroke_emboss_shader_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_write, .csr_index, .csr_data, .fail_count, .pending, .words_out
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && words_out >= 20) begin
            held      = 1'b1;
            rsp_stall = 1'b1;
            repeat (3000) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = !calm && ($urandom_range(0, 99) < 18);
         end
      end
   end

   task automatic push_word(ses_cmd_type cmd, int x, int y, bit ink);
      if (!calm && $urandom_range(0, 99) < 18) begin
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data  = '{cmd: cmd, pos_x: 7'(x), pos_y: 7'(y), ink: ink};
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(ses_csr_type idx, int value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = 8'(value);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // a read cannot start before the previous word is done, so it drains the block
   task automatic drain();
      push_word(CMD_READ, 0, 0, 1'b0);
      wait (pending == 0);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      int fw;
      int fh;
      int p;
      int r;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      calm      = 1'b0;
      cx        = 0;
      cy        = 0;
      quiet     = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      push_word(CMD_READ, 0, 0, 1'b0);
      push_word(CMD_READ, 127, 127, 1'b1);
      drain();
      write_reg(CSR_RADIUS, 3);
      push_word(CMD_STAMP, 0, 0, 1'b1);
      push_word(CMD_STAMP, 127, 127, 1'b1);
      push_word(CMD_STAMP, 64, 64, 1'b0);
      push_word(CMD_NOP, 127, 0, 1'b1);
      push_word(CMD_READ, 0, 0, 1'b0);
      push_word(CMD_READ, 1, 0, 1'b0);
      push_word(CMD_READ, 0, 2, 1'b0);
      push_word(CMD_READ, 2, 2, 1'b0);
      push_word(CMD_READ, 127, 127, 1'b0);
      push_word(CMD_READ, 126, 127, 1'b0);
      push_word(CMD_READ, 64, 64, 1'b0);
      push_word(CMD_STAMP, 10, 10, 1'b1);
      push_word(CMD_STAMP, 11, 10, 1'b1);
      push_word(CMD_READ, 10, 10, 1'b0);
      push_word(CMD_READ, 11, 10, 1'b0);
      push_word(CMD_READ, 12, 10, 1'b0);
      push_word(CMD_READ, 10, 12, 1'b0);
      push_word(CMD_CLEAR, 0, 0, 1'b0);
      push_word(CMD_READ, 0, 0, 1'b0);
      push_word(CMD_STAMP, 5, 5, 1'b1);
      push_word(CMD_READ, 5, 5, 1'b0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         write_reg(CSR_RADIUS, ph_radius[ph]);
         write_reg(CSR_WIDTH, ph_cols[ph]);
         write_reg(CSR_HEIGHT, ph_rows[ph]);
         calm = (ph == 0);
         fw   = (ph_cols[ph] > MAP_WIDTH) ? MAP_WIDTH : ph_cols[ph];
         fh   = (ph_rows[ph] > MAP_HEIGHT) ? MAP_HEIGHT : ph_rows[ph];
         r    = ph_radius[ph] + 1;
         for (int k = 0; k < ph_words[ph]; k++) begin
            p = $urandom_range(0, 199);
            if (p < 80) begin
               if (fw == 0 || fh == 0 || p < 8) begin
                  cx = $urandom_range(0, 127);
                  cy = $urandom_range(0, 127);
               end else begin
                  cx = $urandom_range(0, fw - 1);
                  cy = $urandom_range(0, fh - 1);
               end
               push_word(CMD_STAMP, cx, cy, $urandom_range(0, 3) != 0);
            end else if (p < 176) begin
               push_word(CMD_READ, (cx + $urandom_range(0, 2 * r) - r) & 127,
                         (cy + $urandom_range(0, 2 * r) - r) & 127, $urandom_range(0, 1));
            end else if (p < 178) begin
               push_word(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1));
            end else if (p < 184) begin
               push_word(CMD_NOP, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1));
            end else begin
               push_word(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1));
            end
         end
         drain();
      end

      calm = 1'b0;
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ stroke_emboss_shader.f @@
rtl/core/ses_pkg.sv
rtl/core/ses_div.sv
rtl/core/ses_sqrt.sv
rtl/core/stroke_emboss_shader.sv
tb/sv/stroke_emboss_shader_checker.sv
tb/sv/stroke_emboss_shader_test.sv
